### hdl/blood_bone_border_voxel_cleaner_assert.svh
// assertion macros for the blood/bone border voxel cleaner checker
`ifndef BLOOD_BONE_BORDER_VOXEL_CLEANER_ASSERT_SVH
`define BLOOD_BONE_BORDER_VOXEL_CLEANER_ASSERT_SVH

// property checked only while out of reset
`define BBVC_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// property that also covers the reset cycles
`define BBVC_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/bbvc_pkg.sv
// shared types, register codes and the voxel cleaning function
package bbvc_pkg;

    localparam int VOX_W  = 16;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    localparam logic [CFG_AW-1:0] REG_BLOOD_LOW  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_BLOOD_HIGH = 3'd1;
    localparam logic [CFG_AW-1:0] REG_BONE_LOW   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_WIDTH      = 3'd3;
    localparam logic [CFG_AW-1:0] REG_HEIGHT     = 3'd4;
    localparam logic [CFG_AW-1:0] REG_DEPTH      = 3'd5;

    localparam logic REQ_DATA  = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam int WIN_N      = 27;
    localparam int WIN_CENTER = 13;

    typedef logic signed [VOX_W-1:0] vox_t;
    typedef vox_t win_t [WIN_N];

    typedef struct packed {
        logic adv;
        logic restart;
    } dly_ctl_t;

    typedef struct packed {
        logic xlo;
        logic xhi;
        logic ylo;
        logic yhi;
        logic zlo;
        logic zhi;
    } bnd_t;

    // window index is dz*9 + dy*3 + dx; index 0 on an axis is the newer side
    function automatic vox_t clean_fn(input win_t win, input bnd_t b, input vox_t bl,
                                      input vox_t bh, input vox_t bone);
        logic hit;
        logic ok;
        vox_t c;
        int   k;
        c   = win[WIN_CENTER];
        hit = 1'b0;
        for (int dz = 0; dz < 3; dz++) begin
            for (int dy = 0; dy < 3; dy++) begin
                for (int dx = 0; dx < 3; dx++) begin
                    k  = dz * 9 + dy * 3 + dx;
                    ok = (k != WIN_CENTER);
                    if (dz == 0) ok = ok && !b.zhi;
                    if (dz == 2) ok = ok && !b.zlo;
                    if (dy == 0) ok = ok && !b.yhi;
                    if (dy == 2) ok = ok && !b.ylo;
                    if (dx == 0) ok = ok && !b.xhi;
                    if (dx == 2) ok = ok && !b.xlo;
                    if (ok && (win[k] >= bone)) hit = 1'b1;
                end
            end
        end
        return (c >= bl && c <= bh && hit) ? bone : c;
    endfunction

endpackage

### hdl/bbvc_delay.sv
// programmable delay line on a single-port memory with registered read
module bbvc_delay #(
    parameter int DEPTH = 256
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bbvc_pkg::dly_ctl_t           ctl,
    input  logic [$clog2(DEPTH)-1:0]     modulus,
    input  logic signed [bbvc_pkg::VOX_W-1:0] din,
    output logic signed [bbvc_pkg::VOX_W-1:0] dout
);
    import bbvc_pkg::*;

    localparam int AW = $clog2(DEPTH);

    vox_t          mem [DEPTH];
    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] ptr_next;
    vox_t          rd_reg;
    vox_t          byp_reg;
    logic          bypass;

    assign bypass   = (modulus == '0);
    assign ptr_next = (ptr_reg == modulus - 1'b1) ? '0 : ptr_reg + 1'b1;
    assign dout     = bypass ? byp_reg : rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.restart) begin
            ptr_reg <= '0;
        end else if (ctl.adv && !bypass) begin
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            mem[ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            rd_reg  <= mem[ptr_reg];
            byp_reg <= din;
        end
    end

endmodule

### hdl/blood_bone_border_voxel_cleaner.sv
// Cleans blood-range voxels that touch bone in a raster-ordered 3D volume. Voxels enter one
// per cycle unless the output stalls; the result for voxel p leaves when voxel
// p + W*H + W + 1 is transferred, and the rest of the volume is drained by flush ticks, one
// result per tick, the final one with tlast. The 3x3x3 window is fed by two plane delays of
// MAX_WIDTH*MAX_HEIGHT entries and six line delays of MAX_WIDTH entries, so the sustained
// rate is one transfer per cycle unless the output stalls. When a volume holds fewer than
// W*H + W + 1 voxels, the first flush tick of that volume holds s_tready low while the window
// is advanced over the missing voxels. The delay memories need no clearing after reset.
module blood_bone_border_voxel_cleaner #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_DEPTH  = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [15:0] voxel_in
    input  logic                          s_tuser,   // [0] req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // [15:0] voxel_out
    output logic                          m_tlast,
    input  logic                          cfg_wen,
    input  logic [bbvc_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [bbvc_pkg::CFG_DW-1:0]   cfg_wdata
);
    import bbvc_pkg::*;

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int DW  = $clog2(MAX_DEPTH + 1);
    localparam int PW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int LW  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);
    localparam int LAW = $clog2(MAX_WIDTH);
    localparam int PAW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int W_RST = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int H_RST = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

    // configuration
    vox_t          bl_reg, bh_reg, bone_reg;
    logic [WW-1:0] w_reg, w_wr;
    logic [HW-1:0] h_reg, h_wr;
    logic [DW-1:0] d_reg, d_wr;
    logic          dim_wr;

    logic [PW-1:0] wh;
    logic [LW-1:0] lag;

    // stream control
    logic [LW-1:0] sat_reg, sat_next;
    logic          in_done_reg, in_done_next;
    logic          pend_reg, pend_next;
    logic [WW-1:0] ix_reg, ix_next, ox_reg, ox_next;
    logic [HW-1:0] iy_reg, iy_next, oy_reg, oy_next;
    logic [DW-1:0] iz_reg, iz_next, oz_reg, oz_next;

    logic out_free, pipe_free, s_xfer, data_take, flush_go, drain_adv;
    logic sat_full, adv, emit, vol_end;
    logic ix_end, iy_end, iz_end, ox_end, oy_end, oz_end;

    // window and stages
    vox_t     adv_val;
    vox_t     src [9];
    win_t     win_reg;
    dly_ctl_t dctl;

    logic stg_vld_reg, stg_vld_next, stg_last_reg;
    bnd_t stg_bnd_reg;
    logic load_out;

    logic m_tvalid_reg, m_tvalid_next, m_tlast_reg;
    vox_t m_tdata_reg;

    assign w_wr = WW'((cfg_wdata[8:0] == 9'd0) ? 1 :
                      ((32'(cfg_wdata[8:0]) > MAX_WIDTH) ? MAX_WIDTH : 32'(cfg_wdata[8:0])));
    assign h_wr = HW'((cfg_wdata[8:0] == 9'd0) ? 1 :
                      ((32'(cfg_wdata[8:0]) > MAX_HEIGHT) ? MAX_HEIGHT : 32'(cfg_wdata[8:0])));
    assign d_wr = DW'((cfg_wdata[10:0] == 11'd0) ? 1 :
                      ((32'(cfg_wdata[10:0]) > MAX_DEPTH) ? MAX_DEPTH : 32'(cfg_wdata[10:0])));
    assign dim_wr = cfg_wen &&
                    (cfg_addr == REG_WIDTH || cfg_addr == REG_HEIGHT || cfg_addr == REG_DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bl_reg   <= 16'sd200;
            bh_reg   <= 16'sd340;
            bone_reg <= 16'sd350;
            w_reg    <= WW'(W_RST);
            h_reg    <= HW'(H_RST);
            d_reg    <= DW'(1);
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                REG_BLOOD_LOW:  bl_reg   <= cfg_wdata;
                REG_BLOOD_HIGH: bh_reg   <= cfg_wdata;
                REG_BONE_LOW:   bone_reg <= cfg_wdata;
                REG_WIDTH:      w_reg    <= w_wr;
                REG_HEIGHT:     h_reg    <= h_wr;
                REG_DEPTH:      d_reg    <= d_wr;
                default:        ;
            endcase
        end
    end

    assign wh  = PW'(w_reg * h_reg);
    assign lag = LW'(wh) + LW'(w_reg) + LW'(1);

    assign out_free  = !m_tvalid_reg || m_tready;
    assign pipe_free = !stg_vld_reg || out_free;
    assign s_tready  = pipe_free && !pend_reg;
    assign s_xfer    = s_tvalid && s_tready;
    assign sat_full  = (sat_reg == lag);
    assign data_take = s_xfer && (s_tuser == REQ_DATA) && !in_done_reg;
    assign flush_go  = s_xfer && (s_tuser == REQ_FLUSH) && in_done_reg;
    assign drain_adv = pend_reg && pipe_free;
    assign adv       = data_take || (flush_go && sat_full) || drain_adv;
    assign emit      = adv && sat_full;
    assign load_out  = stg_vld_reg && out_free;

    assign ix_end = (ix_reg == w_reg - 1'b1);
    assign iy_end = (iy_reg == h_reg - 1'b1);
    assign iz_end = (iz_reg == d_reg - 1'b1);
    assign ox_end = (ox_reg == w_reg - 1'b1);
    assign oy_end = (oy_reg == h_reg - 1'b1);
    assign oz_end = (oz_reg == d_reg - 1'b1);
    assign vol_end = emit && ox_end && oy_end && oz_end;

    always_comb begin
        ix_next      = ix_reg;
        iy_next      = iy_reg;
        iz_next      = iz_reg;
        in_done_next = in_done_reg;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        oz_next      = oz_reg;
        sat_next     = sat_reg;
        pend_next    = pend_reg;

        if (data_take) begin
            if (ix_end) begin
                ix_next = '0;
                if (iy_end) begin
                    iy_next = '0;
                    if (iz_end) begin
                        iz_next      = '0;
                        in_done_next = 1'b1;
                    end else begin
                        iz_next = iz_reg + 1'b1;
                    end
                end else begin
                    iy_next = iy_reg + 1'b1;
                end
            end else begin
                ix_next = ix_reg + 1'b1;
            end
        end

        if (emit) begin
            if (ox_end) begin
                ox_next = '0;
                if (oy_end) begin
                    oy_next = '0;
                    oz_next = oz_end ? '0 : oz_reg + 1'b1;
                end else begin
                    oy_next = oy_reg + 1'b1;
                end
            end else begin
                ox_next = ox_reg + 1'b1;
            end
        end

        if (adv && !sat_full) begin
            sat_next = sat_reg + 1'b1;
        end

        if (flush_go && !sat_full) begin
            pend_next = 1'b1;
        end else if (drain_adv && sat_full) begin
            pend_next = 1'b0;
        end

        if (vol_end || dim_wr) begin
            ix_next      = '0;
            iy_next      = '0;
            iz_next      = '0;
            ox_next      = '0;
            oy_next      = '0;
            oz_next      = '0;
            in_done_next = 1'b0;
            sat_next     = '0;
            pend_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ix_reg      <= '0;
            iy_reg      <= '0;
            iz_reg      <= '0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            oz_reg      <= '0;
            in_done_reg <= 1'b0;
            sat_reg     <= '0;
            pend_reg    <= 1'b0;
        end else begin
            ix_reg      <= ix_next;
            iy_reg      <= iy_next;
            iz_reg      <= iz_next;
            ox_reg      <= ox_next;
            oy_reg      <= oy_next;
            oz_reg      <= oz_next;
            in_done_reg <= in_done_next;
            sat_reg     <= sat_next;
            pend_reg    <= pend_next;
        end
    end

    // delay lines feeding the window
    assign adv_val      = data_take ? vox_t'(s_tdata) : '0;
    assign src[0]       = adv_val;
    assign dctl.adv     = adv;
    assign dctl.restart = dim_wr;

    bbvc_delay #(.DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_plane1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (dctl),
        .modulus (PAW'(wh - 1'b1)),
        .din     (src[0]),
        .dout    (src[3])
    );

    bbvc_delay #(.DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_plane2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (dctl),
        .modulus (PAW'(wh - 1'b1)),
        .din     (src[3]),
        .dout    (src[6])
    );

    for (genvar g = 0; g < 3; g++) begin : g_line
        bbvc_delay #(.DEPTH(MAX_WIDTH)) u_line1 (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (dctl),
            .modulus (LAW'(w_reg - 1'b1)),
            .din     (src[g*3]),
            .dout    (src[g*3+1])
        );
        bbvc_delay #(.DEPTH(MAX_WIDTH)) u_line2 (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (dctl),
            .modulus (LAW'(w_reg - 1'b1)),
            .din     (src[g*3+1]),
            .dout    (src[g*3+2])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 9; r++) begin
                win_reg[r*3]   <= src[r];
                win_reg[r*3+1] <= win_reg[r*3];
                win_reg[r*3+2] <= win_reg[r*3+1];
            end
        end
    end

    // window stage, then output register
    assign stg_vld_next = emit ? 1'b1 : (load_out ? 1'b0 : stg_vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_vld_reg <= 1'b0;
        end else begin
            stg_vld_reg <= stg_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            stg_last_reg    <= ox_end && oy_end && oz_end;
            stg_bnd_reg.xlo <= (ox_reg == '0);
            stg_bnd_reg.xhi <= ox_end;
            stg_bnd_reg.ylo <= (oy_reg == '0);
            stg_bnd_reg.yhi <= oy_end;
            stg_bnd_reg.zlo <= (oz_reg == '0);
            stg_bnd_reg.zhi <= oz_end;
        end
    end

    assign m_tvalid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= clean_fn(win_reg, stg_bnd_reg, bl_reg, bh_reg, bone_reg);
            m_tlast_reg <= stg_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### hdl/bbvc_checker.sv
// port-level checker for the voxel cleaner and its bind
`include "blood_bone_border_voxel_cleaner_assert.svh"

module bbvc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // stalled result holds
    `BBVC_ASSERT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    // reset empties the result register
    `BBVC_ASSERT_RST(a_rst_empty, !aresetn, !m_tvalid, "result valid right after reset")

    // reset leaves the block ready for a transfer
    `BBVC_ASSERT_RST(a_rst_ready, !aresetn, s_tready, "not ready right after reset")

endmodule

bind blood_bone_border_voxel_cleaner bbvc_checker u_bbvc_checker (.*);

### tb/sv/blood_bone_border_voxel_cleaner_tb.sv
// testbench for the blood/bone border voxel cleaner with a self-checking stream model
`timescale 1ns / 1ps

module blood_bone_border_voxel_cleaner_tb;
    import bbvc_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int M_W = 256;
    localparam int M_H = 256;
    localparam int M_D = 1024;

    typedef struct {
        logic req;
        vox_t val;
    } vox_req_t;

    typedef struct {
        vox_t val;
        logic last;
    } clean_vox_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] voxel_in
    logic        s_tuser;   // [0] req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] voxel_out
    logic        m_tlast;
    logic        cfg_wen;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_DW-1:0] cfg_wdata;

    vox_req_t   pend_q[$];
    clean_vox_t cleaned_q[$];
    vox_t       vol_hist[int];
    int         in_pos, out_pos;
    vox_t       blood_lo, blood_hi, bone_th;
    int         dim_w, dim_h, dim_d;
    int         err_cnt, cycles, n_voxels, n_flush, n_results, n_volumes;
    int         src_idle, snk_idle;
    bit         quiet, taken;

    blood_bone_border_voxel_cleaner u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int clamp_dim(int v, int maxv);
        if (v == 0) return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic vox_t clean_at(int p);
        int   x, y, z, ix, iy, iz;
        vox_t c;
        x = p % dim_w;
        y = (p / dim_w) % dim_h;
        z = p / (dim_w * dim_h);
        c = vol_hist[p];
        if (c < blood_lo || c > blood_hi) return c;
        for (int dz = -1; dz <= 1; dz++) begin
            for (int dy = -1; dy <= 1; dy++) begin
                for (int dx = -1; dx <= 1; dx++) begin
                    iz = z + dz;
                    iy = y + dy;
                    ix = x + dx;
                    if (iz < 0 || iz >= dim_d || iy < 0 || iy >= dim_h) continue;
                    if (ix < 0 || ix >= dim_w) continue;
                    if (dx == 0 && dy == 0 && dz == 0) continue;
                    if (vol_hist[(iz * dim_h + iy) * dim_w + ix] >= bone_th) return bone_th;
                end
            end
        end
        return c;
    endfunction

    task automatic emit_clean(int p, int total);
        clean_vox_t e;
        e.val  = clean_at(p);
        e.last = (p + 1 == total);
        cleaned_q.push_back(e);
        out_pos = p + 1;
        if (out_pos >= total) begin
            in_pos  = 0;
            out_pos = 0;
            vol_hist.delete();
            n_volumes++;
        end
    endtask

    task automatic predict_transfer(logic req, vox_t v);
        int total, lag, q;
        total = dim_w * dim_h * dim_d;
        lag   = dim_w * dim_h + dim_w + 1;
        if (req == REQ_DATA) begin
            n_voxels++;
            if (in_pos >= total) return;
            q = in_pos;
            vol_hist[q] = v;
            in_pos = q + 1;
            if (q >= lag && out_pos == q - lag) emit_clean(q - lag, total);
        end else begin
            n_flush++;
            if (in_pos >= total && out_pos < total) emit_clean(out_pos, total);
        end
    endtask

    // sender
    always @(posedge aclk) begin
        taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            predict_transfer(s_tuser, vox_t'(s_tdata));
        end
    end

    always @(negedge aclk) begin
        vox_req_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tuser  <= REQ_DATA;
            s_tdata  <= '0;
        end else if (!s_tvalid || taken) begin
            if (src_idle > 0) begin
                src_idle--;
                s_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                src_idle = $urandom_range(1, 10);
                s_tvalid <= 1'b0;
            end else if (pend_q.size() != 0) begin
                it = pend_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= it.req;
                s_tdata  <= it.val;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (snk_idle > 0) begin
            snk_idle--;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
            snk_idle = $urandom_range(1, 10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        clean_vox_t e;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (cleaned_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) $display("unexpected transfer: voxel %0d last %0b",
                                            $signed(m_tdata), m_tlast);
            end else begin
                e = cleaned_q.pop_front();
                if (vox_t'(m_tdata) !== e.val || m_tlast !== e.last) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: voxel exp %0d got %0d, last exp %0b got %0b",
                                 e.val, $signed(m_tdata), e.last, m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic wait_drained();
        do @(posedge aclk); while (pend_q.size() != 0 || s_tvalid || cleaned_q.size() != 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, int value);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value[CFG_DW-1:0];
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        case (idx)
            REG_BLOOD_LOW:  blood_lo = vox_t'(value[15:0]);
            REG_BLOOD_HIGH: blood_hi = vox_t'(value[15:0]);
            REG_BONE_LOW:   bone_th  = vox_t'(value[15:0]);
            REG_WIDTH:      dim_w = clamp_dim(value & 9'h1ff, M_W);
            REG_HEIGHT:     dim_h = clamp_dim(value & 9'h1ff, M_H);
            REG_DEPTH:      dim_d = clamp_dim(value & 11'h7ff, M_D);
            default: ;
        endcase
        if (idx == REG_WIDTH || idx == REG_HEIGHT || idx == REG_DEPTH) begin
            in_pos  = 0;
            out_pos = 0;
            vol_hist.delete();
        end
    endtask

    task automatic write_all(int bl, int bh, int bone, int w, int h, int d);
        write_reg(REG_BLOOD_LOW, bl);
        write_reg(REG_BLOOD_HIGH, bh);
        write_reg(REG_BONE_LOW, bone);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_DEPTH, d);
    endtask

    task automatic push_item(logic req, vox_t v);
        vox_req_t it;
        it.req = req;
        it.val = v;
        pend_q.push_back(it);
    endtask

    function automatic vox_t pick_val();
        case ($urandom_range(0, 7))
            0, 1: return (blood_lo <= blood_hi) ?
                      vox_t'($urandom_range(int'(blood_hi) + 32768, int'(blood_lo) + 32768)
                             - 32768) : blood_lo;
            2: return bone_th;
            3: return (bone_th == 16'sh7fff) ? bone_th : vox_t'(bone_th + 1);
            4: return vox_t'($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
            5: return $urandom_range(0, 1) ? blood_lo : blood_hi;
            default: return vox_t'($urandom());
        endcase
    endfunction

    // one whole volume with optional noise: early flushes and ignored data before the drain
    task automatic gen_volume(int noise);
        int total, lag, drain;
        total = dim_w * dim_h * dim_d;
        lag   = dim_w * dim_h + dim_w + 1;
        drain = (total < lag) ? total : lag;
        for (int i = 0; i < total; i++) begin
            if (noise && $urandom_range(0, 14) == 0) push_item(REQ_FLUSH, vox_t'($urandom()));
            push_item(REQ_DATA, pick_val());
        end
        if (noise) repeat ($urandom_range(0, 2)) push_item(REQ_DATA, vox_t'($urandom()));
        repeat (drain) push_item(REQ_FLUSH, vox_t'($urandom()));
        if (noise) repeat ($urandom_range(0, 2)) push_item(REQ_FLUSH, vox_t'($urandom()));
    endtask

    initial begin
        int bl, bh;
        aresetn   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        blood_lo  = 16'sd200;
        blood_hi  = 16'sd340;
        bone_th   = 16'sd350;
        dim_w = 256;
        dim_h = 256;
        dim_d = 1;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // flush with nothing received
        push_item(REQ_FLUSH, 16'sd0);
        wait_drained();

        write_all(200, 340, 350, 3, 3, 2);
        push_item(REQ_DATA, 16'sh7fff);
        push_item(REQ_DATA, 16'sd200);
        push_item(REQ_FLUSH, 16'sd0);
        push_item(REQ_DATA, 16'sd340);
        push_item(REQ_DATA, 16'sh8000);
        push_item(REQ_DATA, 16'sd199);
        push_item(REQ_DATA, 16'sd341);
        push_item(REQ_DATA, 16'sd349);
        for (int i = 0; i < 11; i++) push_item(REQ_DATA, (i % 3 == 0) ? 16'sd350 : 16'sd250);
        push_item(REQ_DATA, 16'sd1000);
        repeat (14) push_item(REQ_FLUSH, 16'sd0);
        wait_drained();

        // threshold change in the middle of a volume
        write_all(-32768, 32767, 0, 2, 2, 2);
        repeat (4) push_item(REQ_DATA, vox_t'($urandom_range(0, 200) - 100));
        wait_drained();
        write_reg(REG_BONE_LOW, 50);
        repeat (4) push_item(REQ_DATA, vox_t'($urandom_range(0, 200) - 100));
        repeat (7) push_item(REQ_FLUSH, 16'sd0);
        wait_drained();

        // dimension extremes and clamping
        write_all(-32768, 32767, -32768, 0, 0, 0);
        gen_volume(1);
        wait_drained();
        write_all(0, 1000, 500, 511, 1, 1);
        gen_volume(1);
        wait_drained();
        write_all(-32768, -1, 32767, 2, 40, 1);
        gen_volume(0);
        wait_drained();
        write_all(100, 50, 0, 1, 1, 5);
        gen_volume(0);
        wait_drained();
        write_all(-5, 5, 3, 2, 3, 1024);
        repeat (40) push_item(REQ_DATA, pick_val());
        wait_drained();

        for (int ph = 0; ph < 11; ph++) begin
            if (ph >= 9) quiet = 1'b1;
            bl = $urandom_range(0, 65535) - 32768;
            bh = bl + $urandom_range(0, 2000);
            if (bh > 32767) bh = 32767;
            if ($urandom_range(0, 7) == 0) bh = bl - 1;
            write_all(bl, bh, bh + $urandom_range(0, 400) - 100,
                      $urandom_range(1, 6), $urandom_range(1, 5), $urandom_range(1, 4));
            repeat ($urandom_range(1, 3)) gen_volume(1);
            if (ph % 4 == 3) repeat ($urandom_range(1, 5)) push_item(REQ_DATA, pick_val());
            wait_drained();
        end

        $display("transfers in: %0d voxels, %0d flush ticks; results checked: %0d",
                 n_voxels, n_flush, n_results);
        $display("volumes completed: %0d, mismatches: %0d", n_volumes, err_cnt);
        if (err_cnt == 0 && cleaned_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
